[rtl/core/osan_pkg.sv]
// osan_pkg: shared types, constants and the integration time table for the
// light sensor autoranging normaliser. No dependencies.
`default_nettype none
package osan_pkg;

    localparam int TABLE_ENTRIES_DEF = 19;
    localparam int IDX_W   = 5;
    localparam int RAW_W   = 16;
    localparam int SHIFT   = 4;
    localparam int NUM_W   = RAW_W - SHIFT;
    localparam int TIME_W  = 10;
    localparam int PROD_W  = NUM_W + TIME_W;
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int VAL_W   = 16;
    localparam int CODE_W  = 8;
    localparam int OUT_W   = 40;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [7:0] CMD_SETTING_REG = 8'h08;
    localparam logic [7:0] CMD_CONTROL_REG = 8'h40;

    localparam logic [2:0] REG_THR_HIGH  = 3'd0;
    localparam logic [2:0] REG_THR_LOW   = 3'd1;
    localparam logic [2:0] REG_IDX_MIN   = 3'd2;
    localparam logic [2:0] REG_IDX_MAX   = 3'd3;
    localparam logic [2:0] REG_IDX_BASE  = 3'd4;
    localparam logic [2:0] REG_FILTER    = 3'd5;
    localparam logic [2:0] REG_RST_CODE  = 3'd6;
    localparam logic [2:0] REG_RUN_CODE  = 3'd7;

    localparam logic [TIME_W-1:0] TIME_TABLE [32] = '{
        10'd4,   10'd6,   10'd8,   10'd10,  10'd15,  10'd20,  10'd25,  10'd30,
        10'd40,  10'd55,  10'd70,  10'd90,  10'd110, 10'd150, 10'd200, 10'd250,
        10'd350, 10'd450, 10'd550, 10'd550, 10'd550, 10'd550, 10'd550, 10'd550,
        10'd550, 10'd550, 10'd550, 10'd550, 10'd550, 10'd550, 10'd550, 10'd550
    };

    typedef struct packed {
        logic [RAW_W-1:0]  threshold_high;
        logic [RAW_W-1:0]  threshold_low;
        logic [IDX_W-1:0]  index_minimum;
        logic [IDX_W-1:0]  index_maximum;
        logic [IDX_W-1:0]  index_base;
        logic [CODE_W-1:0] filter_code;
        logic [CODE_W-1:0] reset_code;
        logic [CODE_W-1:0] run_code;
    } t_cfg;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [IDX_W-1:0] old_idx;
        logic [IDX_W-1:0] new_idx;
        logic             changed;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SET,
        ST_RST,
        ST_RUN,
        ST_SMP
    } t_back_state;

    function automatic logic [TIME_W-1:0] time_at(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] top);
        logic [IDX_W-1:0] sel;
        sel = (idx > top) ? top : idx;
        return TIME_TABLE[sel];
    endfunction

endpackage
`default_nettype wire

[rtl/core/osan_front.sv]
// osan_front: takes raw samples, steps the integration time index and
// queues one job per beat. Depends on osan_pkg.
`default_nettype none
module osan_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [osan_pkg::RAW_W-1:0] i_raw,
    input  wire osan_pkg::t_cfg             i_cfg,
    input  wire logic                       i_full,
    output logic                            o_push,
    output osan_pkg::t_job                  o_job
);

    logic [osan_pkg::IDX_W-1:0] r_time_index;
    logic [osan_pkg::IDX_W-1:0] n_time_index;
    logic                       step_dn;
    logic                       step_up;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        step_dn = (i_raw > i_cfg.threshold_high) && (r_time_index > i_cfg.index_minimum);
        step_up = (i_raw < i_cfg.threshold_low) && (r_time_index < i_cfg.index_maximum);
        if (step_dn) begin
            n_time_index = r_time_index - 1'b1;
        end else if (step_up) begin
            n_time_index = r_time_index + 1'b1;
        end else begin
            n_time_index = r_time_index;
        end
        o_job.num     = i_raw[osan_pkg::RAW_W-1:osan_pkg::SHIFT];
        o_job.old_idx = r_time_index;
        o_job.new_idx = n_time_index;
        o_job.changed = step_dn || step_up;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_index <= '0;
        end else if (o_push) begin
            r_time_index <= n_time_index;
        end
    end

endmodule
`default_nettype wire

[rtl/core/osan_queue.sv]
// osan_queue: two-entry job queue between the front and back parts.
// Depends on osan_pkg.
`default_nettype none
module osan_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire osan_pkg::t_job i_job,
    input  wire logic           i_pop,
    output osan_pkg::t_job      o_job,
    output logic                o_full,
    output logic                o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    osan_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/osan_back.sv]
// osan_back: scales each queued sample with a serial divider and sends the
// sensor command beats and the sample beat. Depends on osan_pkg.
`default_nettype none
module osan_back #(
    parameter int TABLE_ENTRIES = osan_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire osan_pkg::t_cfg             i_cfg,
    input  wire logic                       i_empty,
    input  wire osan_pkg::t_job             i_job,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [osan_pkg::OUT_W-1:0]      o_tdata,
    output logic                            o_tuser,
    output logic                            o_tlast
);

    localparam logic [osan_pkg::IDX_W-1:0] TOP_IDX = osan_pkg::IDX_W'(TABLE_ENTRIES - 1);

    osan_pkg::t_back_state r_state;
    osan_pkg::t_back_state n_state;

    logic [osan_pkg::NUM_W-1:0]  r_num;
    logic [osan_pkg::IDX_W-1:0]  r_new_idx;
    logic                        r_changed;
    logic [osan_pkg::TIME_W-1:0] r_div;
    logic [osan_pkg::TIME_W-1:0] r_rem;
    logic [osan_pkg::PROD_W-1:0] r_quot;
    logic [osan_pkg::CNT_W-1:0]  r_cnt;

    logic                        r_out_valid;
    logic                        r_out_kind;
    logic                        r_out_last;
    logic [osan_pkg::OUT_W-1:0]  r_out_data;

    logic                        out_free;
    logic                        load;
    logic                        n_kind;
    logic                        n_last;
    logic [15:0]                 n_cmd;
    logic [osan_pkg::VAL_W-1:0]  n_val;
    logic                        n_sat;
    logic [osan_pkg::TIME_W:0]   rem_sh;
    logic                        q_bit;
    logic [osan_pkg::TIME_W-1:0] rem_nx;

    assign out_free = !r_out_valid || i_tready;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_kind;
    assign o_tlast  = r_out_last;

    always_comb begin
        rem_sh = {r_rem, r_quot[osan_pkg::PROD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
        rem_nx = q_bit ? osan_pkg::TIME_W'(rem_sh - {1'b0, r_div})
                       : rem_sh[osan_pkg::TIME_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        n_kind  = 1'b0;
        n_last  = 1'b0;
        n_cmd   = '0;
        n_val   = '0;
        n_sat   = 1'b0;
        case (r_state)
            osan_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = osan_pkg::ST_MUL;
                end
            end
            osan_pkg::ST_MUL: begin
                n_state = osan_pkg::ST_DIV;
            end
            osan_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_changed ? osan_pkg::ST_SET : osan_pkg::ST_RUN;
                end
            end
            osan_pkg::ST_SET: begin
                n_cmd = {osan_pkg::CMD_SETTING_REG,
                         i_cfg.filter_code | {3'b000, r_new_idx}};
                if (out_free) begin
                    load    = 1'b1;
                    n_state = osan_pkg::ST_RST;
                end
            end
            osan_pkg::ST_RST: begin
                n_cmd = {osan_pkg::CMD_CONTROL_REG, i_cfg.reset_code};
                if (out_free) begin
                    load    = 1'b1;
                    n_state = osan_pkg::ST_RUN;
                end
            end
            osan_pkg::ST_RUN: begin
                n_cmd = {osan_pkg::CMD_CONTROL_REG, i_cfg.run_code};
                if (out_free) begin
                    load    = 1'b1;
                    n_state = osan_pkg::ST_SMP;
                end
            end
            osan_pkg::ST_SMP: begin
                n_kind = 1'b1;
                n_last = 1'b1;
                n_sat  = |r_quot[osan_pkg::PROD_W-1:osan_pkg::VAL_W];
                n_val  = n_sat ? '1 : r_quot[osan_pkg::VAL_W-1:0];
                if (out_free) begin
                    load    = 1'b1;
                    n_state = osan_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = osan_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osan_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            osan_pkg::ST_IDLE: begin
                r_num     <= i_job.num;
                r_new_idx <= i_job.new_idx;
                r_changed <= i_job.changed;
                r_div     <= osan_pkg::time_at(i_job.old_idx, TOP_IDX);
            end
            osan_pkg::ST_MUL: begin
                r_quot <= osan_pkg::PROD_W'(r_num) *
                          osan_pkg::PROD_W'(osan_pkg::time_at(i_cfg.index_base, TOP_IDX));
                r_rem  <= '0;
                r_cnt  <= osan_pkg::CNT_W'(osan_pkg::PROD_W - 1);
            end
            osan_pkg::ST_DIV: begin
                r_quot <= {r_quot[osan_pkg::PROD_W-2:0], q_bit};
                r_rem  <= rem_nx;
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
                r_quot <= r_quot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= n_kind;
            r_out_last <= n_last;
            r_out_data <= {2'b00, r_new_idx, n_sat, n_val, n_cmd};
        end
    end

endmodule
`default_nettype wire

[rtl/core/optical_sensor_autorange_normalizer_unit.sv]
// optical_sensor_autorange_normalizer_unit: top level with the register
// file, front part, job queue and back part. Depends on osan_pkg and the osan modules.
//
// Input stream: one raw 16-bit light sample per beat on s_axis. Output stream:
// per sample either four beats (integration setting command, sensor reset
// command, run command, scaled sample) when the integration time index moved,
// or two beats (run command, scaled sample). tuser is 1 on the sample beat,
// which also carries tlast. The index moves at most one step per sample.
// Registers sit on the APB port at byte addresses 4*i, pready always high.
// Flow: the front takes a sample and queues it (two jobs deep) while the
// queue is not full. The back part handles one sample at a time: it fetches
// the job, does the multiply and runs the bit-serial restoring divider, then
// sends one output beat per cycle while the receiver accepts them, and only
// then fetches the next job.
// A stalled receiver holds the output register; the back part waits and
// the queue fills, after which s_axis_tready drops.
// Synchronous reset clears the index to zero, the registers to their
// defaults, the queue and the output valid. No clearing pass is needed.
`default_nettype none
module optical_sensor_autorange_normalizer_unit #(
    parameter int TABLE_ENTRIES = osan_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // [15:0] raw_sample
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [15:0] command_word, [31:16] normalized_value, [32] saturated,
    // [37:33] current_index, [39:38] zero
    output logic [osan_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic [0:0]                         m_axis_tuser,  // [0] result_kind
    output logic                               m_axis_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [osan_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [osan_pkg::DATA_W-1:0]   pwdata,
    output logic [osan_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    osan_pkg::t_cfg r_cfg;
    osan_pkg::t_job front_job;
    osan_pkg::t_job queue_job;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic           wr_en;
    logic [2:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_high <= 16'hFFFF;
            r_cfg.threshold_low  <= '0;
            r_cfg.index_minimum  <= '0;
            r_cfg.index_maximum  <= 5'd18;
            r_cfg.index_base     <= '0;
            r_cfg.filter_code    <= '0;
            r_cfg.reset_code     <= '0;
            r_cfg.run_code       <= 8'd4;
        end else if (wr_en) begin
            case (reg_sel)
                osan_pkg::REG_THR_HIGH: r_cfg.threshold_high <= pwdata[15:0];
                osan_pkg::REG_THR_LOW:  r_cfg.threshold_low  <= pwdata[15:0];
                osan_pkg::REG_IDX_MIN:  r_cfg.index_minimum  <= pwdata[4:0];
                osan_pkg::REG_IDX_MAX:  r_cfg.index_maximum  <= pwdata[4:0];
                osan_pkg::REG_IDX_BASE: r_cfg.index_base     <= pwdata[4:0];
                osan_pkg::REG_FILTER:   r_cfg.filter_code    <= pwdata[7:0];
                osan_pkg::REG_RST_CODE: r_cfg.reset_code     <= pwdata[7:0];
                osan_pkg::REG_RUN_CODE: r_cfg.run_code       <= pwdata[7:0];
                default:                r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            osan_pkg::REG_THR_HIGH: prdata = {16'h0000, r_cfg.threshold_high};
            osan_pkg::REG_THR_LOW:  prdata = {16'h0000, r_cfg.threshold_low};
            osan_pkg::REG_IDX_MIN:  prdata = {27'd0, r_cfg.index_minimum};
            osan_pkg::REG_IDX_MAX:  prdata = {27'd0, r_cfg.index_maximum};
            osan_pkg::REG_IDX_BASE: prdata = {27'd0, r_cfg.index_base};
            osan_pkg::REG_FILTER:   prdata = {24'd0, r_cfg.filter_code};
            osan_pkg::REG_RST_CODE: prdata = {24'd0, r_cfg.reset_code};
            osan_pkg::REG_RUN_CODE: prdata = {24'd0, r_cfg.run_code};
            default:                prdata = '0;
        endcase
    end

    osan_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_raw   (s_axis_tdata),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    osan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    osan_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_job    (queue_job),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser[0]),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

[rtl/core/osan_checker.sv]
// osan_checker: port-level checks of the output stream, bound to the top
// level. Depends on osan_pkg.
`default_nettype none
module osan_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [osan_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire logic [0:0]                  m_axis_tuser,
    input wire logic                        m_axis_tlast
);

    // stalled beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // only the sample beat closes a sample
    a_last_is_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
        else $error("tlast and result kind disagree");

    a_sample_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[15:0] == 16'h0000))
        else $error("command word set on sample beat");

    a_cmd_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[32:16] == 17'd0))
        else $error("value or saturation set on command beat");

endmodule

bind optical_sensor_autorange_normalizer_unit osan_checker u_osan_checker (.*);
`default_nettype wire
